// ===== rtl/acit_pkg.sv =====
package acit_pkg;

    localparam int unsigned CoordW = 13;
    localparam int unsigned WtW    = 12;
    localparam int unsigned TotW   = 13;
    localparam int unsigned DenW   = 21;
    localparam int unsigned ProdW  = 28;
    localparam int unsigned NumW   = 29;
    localparam int unsigned ChanW  = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned NumCh  = 3;
    localparam int unsigned NumDir = 6;

    typedef logic [2:0] t_face;
    localparam t_face FACE_POS_X = 3'd0;
    localparam t_face FACE_NEG_X = 3'd1;
    localparam t_face FACE_POS_Y = 3'd2;
    localparam t_face FACE_NEG_Y = 3'd3;
    localparam t_face FACE_POS_Z = 3'd4;
    localparam t_face FACE_NEG_Z = 3'd5;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_FACE_SIZE = 3'd0;
    localparam t_reg_idx REG_COLOR_PX  = 3'd1;
    localparam t_reg_idx REG_COLOR_NX  = 3'd2;
    localparam t_reg_idx REG_COLOR_PY  = 3'd3;
    localparam t_reg_idx REG_COLOR_NY  = 3'd4;
    localparam t_reg_idx REG_COLOR_PZ  = 3'd5;
    localparam t_reg_idx REG_COLOR_NZ  = 3'd6;
    localparam t_reg_idx REG_GAIN      = 3'd7;

    localparam logic [10:0] FACE_SIZE_RESET = 11'd32;
    localparam logic [15:0] GAIN_RESET      = 16'd36045;
    localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;
    localparam logic [7:0]  BYTE_SAT        = 8'hFF;

endpackage

// ===== rtl/acit_div.sv =====
module acit_div (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  logic                                                  i_vld,
    input  logic [acit_pkg::NumCh-1:0][acit_pkg::NumW-1:0]        i_num,
    input  logic [acit_pkg::DenW-1:0]                             i_den,
    output logic                                                  o_vld,
    output logic [acit_pkg::NumCh-1:0][acit_pkg::ByteW-1:0]       o_byte
);

    localparam int unsigned Steps = acit_pkg::ByteW;

    logic                                                r_vld  [0:Steps];
    logic [acit_pkg::NumCh-1:0][acit_pkg::NumW-1:0]      r_rem  [0:Steps];
    logic [acit_pkg::NumCh-1:0][acit_pkg::ByteW-1:0]     r_quo  [0:Steps];
    logic [acit_pkg::NumCh-1:0]                          r_sat  [0:Steps];
    logic                                                r_zero [0:Steps];
    logic [acit_pkg::DenW-1:0]                           r_den  [0:Steps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_zero[0] <= (i_den == '0);
            for (int c = 0; c < acit_pkg::NumCh; c++) begin
                r_sat[0][c] <= (i_num[c] >= {i_den, 8'b0});
            end
        end
    end

    for (genvar k = 1; k <= Steps; k++) begin : g_step
        logic [acit_pkg::NumW-1:0]                           dsh;
        logic [acit_pkg::NumCh-1:0][acit_pkg::NumW-1:0]      n_rem;
        logic [acit_pkg::NumCh-1:0][acit_pkg::ByteW-1:0]     n_quo;

        always_comb begin
            dsh = {r_den[k-1], 8'b0} >> k;
            for (int c = 0; c < acit_pkg::NumCh; c++) begin
                n_rem[c] = r_rem[k-1][c];
                n_quo[c] = r_quo[k-1][c];
                if (r_rem[k-1][c] >= dsh) begin
                    n_rem[c]           = r_rem[k-1][c] - dsh;
                    n_quo[c][Steps-k]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_sat[k]  <= r_sat[k-1];
                r_zero[k] <= r_zero[k-1];
                r_den[k]  <= r_den[k-1];
            end
        end
    end

    assign o_vld = r_vld[Steps];

    always_comb begin
        for (int c = 0; c < acit_pkg::NumCh; c++) begin
            if (r_zero[Steps]) begin
                o_byte[c] = '0;
            end else if (r_sat[Steps][c]) begin
                o_byte[c] = acit_pkg::BYTE_SAT;
            end else begin
                o_byte[c] = r_quo[Steps][c];
            end
        end
    end

`ifndef SYNTHESIS
    // zero total weight must come with an all-zero numerator
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_zero[0] |-> r_rem[0] == '0)
        else $error("zero denominator with nonzero numerator");

    a_rem_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !r_zero[Steps] && !r_sat[Steps][0]
        |-> r_rem[Steps][0] < acit_pkg::NumW'(r_den[Steps]))
        else $error("red remainder not below divisor");

    a_rem_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !r_zero[Steps] && !r_sat[Steps][1]
        |-> r_rem[Steps][1] < acit_pkg::NumW'(r_den[Steps]))
        else $error("green remainder not below divisor");

    a_rem_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !r_zero[Steps] && !r_sat[Steps][2]
        |-> r_rem[Steps][2] < acit_pkg::NumW'(r_den[Steps]))
        else $error("blue remainder not below divisor");
`endif

endmodule

// ===== rtl/ambient_cube_irradiance_texel.sv =====
// Ambient-cube irradiance for one cube-map texel per word. A texel word is accepted every
// cycle while the result side takes words; the result passes through the 4 weight/multiply
// stages and the 9-stage restoring divider (an input register, then one quotient bit per
// stage). A stall on the result side freezes the whole pipeline. Registers sit at byte
// address 8*index on the APB port and should only be written while the pipeline is empty.
module ambient_cube_irradiance_texel #(
    parameter int unsigned FACE_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // texel_x[9:0], texel_y[19:10], zero pad
    input  logic [2:0]  s_tuser,   // face[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [10:0]                                          r_face_size;
    logic [acit_pkg::NumDir-1:0][47:0]                    r_color;
    logic [15:0]                                          r_gain;
    acit_pkg::t_reg_idx                                   cfg_idx;
    logic                                                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= acit_pkg::FACE_SIZE_RESET;
            r_color     <= '0;
            r_gain      <= acit_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                acit_pkg::REG_FACE_SIZE: r_face_size <= pwdata[10:0];
                acit_pkg::REG_COLOR_PX,
                acit_pkg::REG_COLOR_NX,
                acit_pkg::REG_COLOR_PY,
                acit_pkg::REG_COLOR_NY,
                acit_pkg::REG_COLOR_PZ,
                acit_pkg::REG_COLOR_NZ: r_color[3'(cfg_idx - 3'd1)] <= pwdata[47:0];
                acit_pkg::REG_GAIN: r_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            acit_pkg::REG_FACE_SIZE: prdata = 64'(r_face_size);
            acit_pkg::REG_COLOR_PX,
            acit_pkg::REG_COLOR_NX,
            acit_pkg::REG_COLOR_PY,
            acit_pkg::REG_COLOR_NY,
            acit_pkg::REG_COLOR_PZ,
            acit_pkg::REG_COLOR_NZ: prdata = 64'(r_color[3'(cfg_idx - 3'd1)]);
            acit_pkg::REG_GAIN: prdata = 64'(r_gain);
            default: prdata = '0;
        endcase
    end

    // pipeline advance
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // direction and weights
    logic [10:0]                                          s_size;
    logic signed [acit_pkg::CoordW-1:0]                   sc, tc, smaj;
    logic signed [acit_pkg::CoordW-1:0]                   d   [0:2];
    logic signed [acit_pkg::CoordW-1:0]                   nd  [0:2];
    logic [acit_pkg::NumDir-1:0][acit_pkg::WtW-1:0]       n_w;

    always_comb begin
        s_size = (13'(r_face_size) > 13'(FACE_MAX)) ? 11'(FACE_MAX) : r_face_size;
        sc   = $signed({2'b0, s_tdata[9:0], 1'b1})  - $signed({2'b0, s_size});
        tc   = $signed({2'b0, s_tdata[19:10], 1'b1}) - $signed({2'b0, s_size});
        smaj = $signed({2'b0, s_size});
        case (s_tuser)
            acit_pkg::FACE_POS_X: begin d[0] = smaj;  d[1] = -tc;   d[2] = -sc;   end
            acit_pkg::FACE_NEG_X: begin d[0] = -smaj; d[1] = -tc;   d[2] = sc;    end
            acit_pkg::FACE_POS_Y: begin d[0] = sc;    d[1] = smaj;  d[2] = tc;    end
            acit_pkg::FACE_NEG_Y: begin d[0] = sc;    d[1] = -smaj; d[2] = -tc;   end
            acit_pkg::FACE_POS_Z: begin d[0] = sc;    d[1] = -tc;   d[2] = smaj;  end
            acit_pkg::FACE_NEG_Z: begin d[0] = -sc;   d[1] = -tc;   d[2] = -smaj; end
            default: begin d[0] = '0; d[1] = 13'sd1; d[2] = '0; end
        endcase
        for (int k = 0; k < 3; k++) begin
            nd[k]         = -d[k];
            n_w[2*k]      = (d[k] > 0) ? d[k][acit_pkg::WtW-1:0]  : '0;
            n_w[2*k + 1]  = (d[k] < 0) ? nd[k][acit_pkg::WtW-1:0] : '0;
        end
    end

    // stage A: weights
    logic                                                 r_a_vld;
    logic [acit_pkg::NumDir-1:0][acit_pkg::WtW-1:0]       r_a_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_w <= n_w;
        end
    end

    // stage B: color products and divisor
    logic [acit_pkg::TotW-1:0]                            tot;
    logic                                                 r_b_vld;
    logic [acit_pkg::NumCh-1:0][acit_pkg::NumDir-1:0][acit_pkg::ProdW-1:0] r_b_prod;
    logic [acit_pkg::DenW-1:0]                            r_b_den;

    assign tot = acit_pkg::TotW'(r_a_w[0]) + acit_pkg::TotW'(r_a_w[1])
               + acit_pkg::TotW'(r_a_w[2]) + acit_pkg::TotW'(r_a_w[3])
               + acit_pkg::TotW'(r_a_w[4]) + acit_pkg::TotW'(r_a_w[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_den <= acit_pkg::DenW'({tot, 8'b0}) + acit_pkg::DenW'(tot);
            for (int c = 0; c < acit_pkg::NumCh; c++) begin
                for (int i = 0; i < acit_pkg::NumDir; i++) begin
                    r_b_prod[c][i] <= acit_pkg::ProdW'(r_color[i][16*c +: 16])
                                    * acit_pkg::ProdW'(r_a_w[i]);
                end
            end
        end
    end

    // stage C: weighted sums
    logic                                                 r_c_vld;
    logic [acit_pkg::NumCh-1:0][acit_pkg::NumW-1:0]       r_c_num;
    logic [acit_pkg::DenW-1:0]                            r_c_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_den <= r_b_den;
            for (int c = 0; c < acit_pkg::NumCh; c++) begin
                r_c_num[c] <= acit_pkg::NumW'(r_b_prod[c][0]) + acit_pkg::NumW'(r_b_prod[c][1])
                            + acit_pkg::NumW'(r_b_prod[c][2]) + acit_pkg::NumW'(r_b_prod[c][3])
                            + acit_pkg::NumW'(r_b_prod[c][4]) + acit_pkg::NumW'(r_b_prod[c][5]);
            end
        end
    end

    // stage D: gain
    logic                                                 r_d_vld;
    logic [acit_pkg::NumCh-1:0][acit_pkg::NumW-1:0]       r_d_q;
    logic [acit_pkg::DenW-1:0]                            r_d_den;
    logic [acit_pkg::NumCh-1:0][acit_pkg::NumW+15:0]      gprod;

    always_comb begin
        for (int c = 0; c < acit_pkg::NumCh; c++) begin
            gprod[c] = (acit_pkg::NumW+16)'(r_c_num[c]) * (acit_pkg::NumW+16)'(r_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_den <= r_c_den;
            for (int c = 0; c < acit_pkg::NumCh; c++) begin
                r_d_q[c] <= gprod[c][acit_pkg::NumW+15:16];
            end
        end
    end

    logic [acit_pkg::NumCh-1:0][acit_pkg::ByteW-1:0]      out_byte;

    acit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_d_vld),
        .i_num   (r_d_q),
        .i_den   (r_d_den),
        .o_vld   (m_tvalid),
        .o_byte  (out_byte)
    );

    assign m_tdata = {acit_pkg::ALPHA_OPAQUE, out_byte[2], out_byte[1], out_byte[0]};

endmodule

// ===== tb/irradiance_checker.sv =====
module irradiance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [10:0] face_size;
    logic [47:0] colors [acit_pkg::NumDir];
    logic [15:0] gain;
    logic [31:0] expected_texels [$];

    function automatic logic [31:0] texel_irradiance(acit_pkg::t_face face, logic [9:0] tx,
                                                     logic [9:0] ty);
        longint s, sc, tc, dx, dy, dz, total, num, val;
        longint w [acit_pkg::NumDir];
        logic [31:0] res;
        s = (face_size > 1024) ? 1024 : face_size;
        sc = 2 * longint'(tx) + 1 - s;
        tc = 2 * longint'(ty) + 1 - s;
        case (face)
            acit_pkg::FACE_POS_X: begin dx = s;   dy = -tc; dz = -sc; end
            acit_pkg::FACE_NEG_X: begin dx = -s;  dy = -tc; dz = sc;  end
            acit_pkg::FACE_POS_Y: begin dx = sc;  dy = s;   dz = tc;  end
            acit_pkg::FACE_NEG_Y: begin dx = sc;  dy = -s;  dz = -tc; end
            acit_pkg::FACE_POS_Z: begin dx = sc;  dy = -tc; dz = s;   end
            acit_pkg::FACE_NEG_Z: begin dx = -sc; dy = -tc; dz = -s;  end
            default:              begin dx = 0;   dy = 1;   dz = 0;   end
        endcase
        w[0] = dx > 0 ? dx : 0;
        w[1] = dx < 0 ? -dx : 0;
        w[2] = dy > 0 ? dy : 0;
        w[3] = dy < 0 ? -dy : 0;
        w[4] = dz > 0 ? dz : 0;
        w[5] = dz < 0 ? -dz : 0;
        total = 0;
        for (int i = 0; i < acit_pkg::NumDir; i++) total += w[i];
        res = {acit_pkg::ALPHA_OPAQUE, 24'd0};
        for (int ch = 0; ch < acit_pkg::NumCh; ch++) begin
            val = 0;
            if (total != 0) begin
                num = 0;
                for (int i = 0; i < acit_pkg::NumDir; i++)
                    num += longint'(colors[i][16*ch +: 16]) * w[i];
                val = (num * longint'(gain)) / (total * 257 * 65536);
                if (val > 255) val = 255;
            end
            res[8*ch +: 8] = val[7:0];
        end
        return res;
    endfunction

    assign o_pending = expected_texels.size();

    always @(posedge i_clk) begin
        logic [31:0] exp_w;
        if (!i_rst_n) begin
            face_size <= acit_pkg::FACE_SIZE_RESET;
            for (int i = 0; i < acit_pkg::NumDir; i++) colors[i] <= '0;
            gain <= acit_pkg::GAIN_RESET;
            o_fail_count <= 0;
            expected_texels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_texels.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word %h", m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_texels.pop_front();
                    if (exp_w !== m_tdata) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected r%0d g%0d b%0d a%0d, ",
                                      "got r%0d g%0d b%0d a%0d"},
                                     exp_w[7:0], exp_w[15:8], exp_w[23:16], exp_w[31:24],
                                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                                     m_tdata[31:24]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_texels = {expected_texels,
                                   texel_irradiance(s_tuser, s_tdata[9:0], s_tdata[19:10])};
            if (psel && penable && pwrite && pready) begin
                case (acit_pkg::t_reg_idx'(paddr[5:3]))
                    acit_pkg::REG_FACE_SIZE: face_size <= pwdata[10:0];
                    acit_pkg::REG_GAIN:      gain <= pwdata[15:0];
                    default:                 colors[3'(paddr[5:3] - 3'd1)] <= pwdata[47:0];
                endcase
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          src_idle_en;
    bit          sink_idle_en;
    bit          hold_req;
    int          sink_hold = 0;
    int          cur_size;

    ambient_cube_irradiance_texel DUT (.*);

    irradiance_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr,
        .pwdata, .pready, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // one long hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req && sink_hold < 200) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold + 1;
        end else begin
            m_tready <= sink_idle_en ? ($urandom_range(0, 99) >= 28) : 1'b1;
        end
    end

    task automatic send_texel(acit_pkg::t_face face, logic [9:0] tx, logic [9:0] ty);
        while (src_idle_en && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= face;
        s_tdata  <= {4'd0, ty, tx};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic reg_write(acit_pkg::t_reg_idx idx, logic [63:0] val);
        s_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'd0};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == acit_pkg::REG_FACE_SIZE) cur_size = int'(val[10:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_color();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    task automatic rand_config();
        int pick;
        pick = $urandom_range(0, 9);
        reg_write(acit_pkg::REG_FACE_SIZE,
                  pick == 0 ? 64'd1 : pick == 1 ? 64'd1024 : pick == 2 ? 64'd2047 :
                  pick == 3 ? 64'd0 : 64'($urandom_range(1, 64)));
        for (int i = 1; i <= acit_pkg::NumDir; i++)
            reg_write(acit_pkg::t_reg_idx'(i), 64'(rand_color()));
        pick = $urandom_range(0, 5);
        reg_write(acit_pkg::REG_GAIN,
                  pick == 0 ? 64'd0 : pick == 1 ? 64'd65535 : 64'($urandom_range(0, 65535)));
    endtask

    task automatic rand_texel();
        int s;
        s = cur_size > 1024 ? 1024 : (cur_size < 1 ? 1 : cur_size);
        if ($urandom_range(0, 9) < 8)
            send_texel(acit_pkg::t_face'($urandom_range(0, 5)), 10'($urandom_range(0, s - 1)),
                       10'($urandom_range(0, s - 1)));
        else
            send_texel(acit_pkg::t_face'($urandom_range(0, 7)), 10'($urandom), 10'($urandom));
    endtask

    initial begin
        s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        src_idle_en = 0; sink_idle_en = 0; hold_req = 0; cur_size = 32;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults from reset, colors all zero
        send_texel(acit_pkg::FACE_POS_X, 10'd0, 10'd0);
        send_texel(acit_pkg::FACE_NEG_Z, 10'd31, 10'd31);
        drain();

        reg_write(acit_pkg::REG_COLOR_PX, 64'hFFFF_FFFF_FFFF);
        reg_write(acit_pkg::REG_COLOR_NX, 64'h1234_5678_9ABC);
        reg_write(acit_pkg::REG_COLOR_PY, 64'hFFFF_0000_8000);
        reg_write(acit_pkg::REG_COLOR_NY, 64'h0001_FFFF_4321);
        reg_write(acit_pkg::REG_COLOR_PZ, 64'hAAAA_5555_FFFF);
        reg_write(acit_pkg::REG_COLOR_NZ, 64'h0F0F_F0F0_0000);
        reg_write(acit_pkg::REG_GAIN, 64'd65535);
        reg_write(acit_pkg::REG_FACE_SIZE, 64'd1024);
        for (int f = 0; f < 8; f++) send_texel(acit_pkg::t_face'(f), 10'd0, 10'd1023);
        send_texel(acit_pkg::FACE_POS_Y, 10'd1023, 10'd0);
        send_texel(acit_pkg::FACE_NEG_Y, 10'd1023, 10'd1023);
        drain();

        reg_write(acit_pkg::REG_FACE_SIZE, 64'd2047);
        send_texel(acit_pkg::FACE_POS_Z, 10'd512, 10'd0);
        drain();
        reg_write(acit_pkg::REG_FACE_SIZE, 64'd1);
        send_texel(acit_pkg::FACE_NEG_X, 10'd0, 10'd0);
        send_texel(acit_pkg::FACE_POS_X, 10'd1023, 10'd1023);
        drain();
        reg_write(acit_pkg::REG_FACE_SIZE, 64'd0);
        reg_write(acit_pkg::REG_GAIN, 64'd0);
        send_texel(acit_pkg::FACE_POS_X, 10'd0, 10'd0);
        send_texel(acit_pkg::FACE_POS_Y, 10'd0, 10'd0);
        drain();
        reg_write(acit_pkg::REG_GAIN, 64'd40000);
        send_texel(acit_pkg::FACE_POS_X, 10'd0, 10'd0);
        send_texel(acit_pkg::FACE_NEG_Z, 10'd0, 10'd0);
        send_texel(3'd6, 10'd5, 10'd7);
        drain();

        // receiver holds off while texels keep coming
        hold_req = 1'b1;
        repeat (40) rand_texel();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            rand_config();
            src_idle_en  = (ph != 2);
            sink_idle_en = (ph != 2);
            repeat (72) rand_texel();
            drain();
        end
        src_idle_en = 0;
        sink_idle_en = 0;

        wait (pending == 0);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
